// ===== hdl/dcc_pkg.sv =====
package dcc_pkg;

  localparam int BIT_STORE_DEPTH = 256;
  localparam int PTR_W           = $clog2(BIT_STORE_DEPTH);
  localparam int FRAME_W         = 6;
  localparam int IDLE_BITS       = 40;
  localparam int PRE_SHORT       = 12;
  localparam int PRE_LONG        = 20;

  // Item kinds on the input channel
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Idle packet, sent MSB first: preamble ones, 0xff address, 0x00 data, 0xff check, end bit.
  localparam logic [IDLE_BITS-1:0] IDLE_PKT = 40'hFF_F7_F8_01_FF;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [FRAME_W-1:0] frame_cnt_t;

  typedef struct packed {
    logic en;
    ptr_t addr;
    logic data;
  } wr_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic stored;
  } frm_stat_t;

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t nxt;
    nxt = (p == PTR_W'(BIT_STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    return nxt;
  endfunction

  function automatic logic idle_bit(logic [5:0] p);
    logic b;
    b = IDLE_PKT[6'(IDLE_BITS - 1) - p];
    return b;
  endfunction

endpackage

// ===== hdl/dcc_if.sv =====
interface dcc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       first_of_packet;
  logic       last_of_packet;
  logic       long_preamble;

  modport source (output valid, command, data_byte, first_of_packet, last_of_packet,
                  long_preamble, input ready);
  modport sink (input valid, command, data_byte, first_of_packet, last_of_packet,
                long_preamble, output ready);
endinterface

interface dcc_out_if;
  logic valid;
  logic ready;
  logic track_a;
  logic track_b;
  logic accepted;

  modport source (output valid, track_a, track_b, accepted, input ready);
  modport sink (input valid, track_a, track_b, accepted, output ready);
endinterface

// ===== hdl/dcc_bit_store.sv =====
module dcc_bit_store (
  input  logic           clk_i,
  input  dcc_pkg::wr_t   wr_i,
  input  dcc_pkg::ptr_t  rd_addr_i,
  output logic           rd_data_o
);

  logic mem [dcc_pkg::BIT_STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== hdl/dcc_framer.sv =====
module dcc_framer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_i,
  input  logic                  last_i,
  input  logic                  long_i,
  input  dcc_pkg::ptr_t         read_pos_i,
  output dcc_pkg::ptr_t         write_pos_o,
  output dcc_pkg::wr_t          wr_o,
  output dcc_pkg::frm_stat_t    stat_o
);

  localparam int CW      = dcc_pkg::PTR_W + 1;
  localparam int FRAME_W = dcc_pkg::FRAME_W;

  logic                 busy_q, done_q, stored_q;
  dcc_pkg::frame_cnt_t  cnt_q, len_q, pre_q;
  logic [7:0]           byte_q, xor_q;
  dcc_pkg::ptr_t        wpos_q;

  dcc_pkg::frame_cnt_t  pre_w, len_w, rel_w;
  logic [CW-1:0]        used_w, room_w;
  logic                 fit_w, bit_w;
  logic [7:0]           xor_w;

  // Frame length and free room for a new byte.
  always_comb begin
    pre_w = '0;
    if (first_i) begin
      pre_w = long_i ? FRAME_W'(dcc_pkg::PRE_LONG) : FRAME_W'(dcc_pkg::PRE_SHORT);
    end
    len_w = pre_w + 6'd9 + (last_i ? 6'd10 : 6'd0);
    if (wpos_q >= read_pos_i) begin
      used_w = {1'b0, wpos_q} - {1'b0, read_pos_i};
    end else begin
      used_w = {1'b0, wpos_q} + CW'(dcc_pkg::BIT_STORE_DEPTH) - {1'b0, read_pos_i};
    end
    room_w = CW'(dcc_pkg::BIT_STORE_DEPTH - 1) - used_w;
    fit_w  = CW'(len_w) <= room_w;
    xor_w  = (first_i ? 8'h00 : xor_q) ^ data_byte_i;
  end

  // Bit at the current frame position: preamble, start, data, separator, check, end.
  always_comb begin
    rel_w = cnt_q - pre_q;
    if (cnt_q < pre_q) begin
      bit_w = 1'b1;
    end else if (rel_w == 6'd0 || rel_w == 6'd9) begin
      bit_w = 1'b0;
    end else if (rel_w <= 6'd8) begin
      bit_w = byte_q[3'(6'd8 - rel_w)];
    end else if (rel_w <= 6'd17) begin
      bit_w = xor_q[3'(6'd17 - rel_w)];
    end else begin
      bit_w = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      stored_q <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      pre_q    <= '0;
      xor_q    <= '0;
      wpos_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        stored_q <= fit_w;
        if (fit_w) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
          len_q  <= len_w;
          pre_q  <= pre_w;
          xor_q  <= xor_w;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        wpos_q <= dcc_pkg::ptr_next(wpos_q);
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == len_q - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      byte_q <= data_byte_i;
    end
  end

  assign write_pos_o   = wpos_q;
  assign wr_o.en       = busy_q;
  assign wr_o.addr     = wpos_q;
  assign wr_o.data     = bit_w;
  assign stat_o.busy   = busy_q;
  assign stat_o.done   = done_q;
  assign stat_o.stored = stored_q;

endmodule

// ===== hdl/dcc_packet_transmitter.sv =====
// DCC track encoder. Packet bytes come in on the input channel and are framed into a
// 256-entry ring of single bits: a first byte adds a preamble of 12 ones (20 with
// long_preamble) and restarts the XOR check, every byte adds a 0 start bit and its eight
// bits MSB first, and a last byte adds a 0, the XOR check byte and a 1 end bit. A byte
// whose framed bits do not all fit in the ring is refused whole (accepted = 0) and
// leaves the check untouched. A tick item is one half-bit time: a one bit lasts two
// ticks and a zero four, and the two bridge lines switch in opposition. With nothing
// queued the lines rest high, or, with idle_fill set, the 40-bit idle packet repeats;
// an idle packet once begun is sent to its end. Every item returns exactly one result
// transfer with the line levels after it. A tick passes through the ring read (S_RD)
// and the line update (S_TICK) before its result is registered; a byte waits in S_BYTE
// while the framer writes its frame one bit per cycle through the ring's single write
// port, and a refused byte writes nothing. One item is in work at a time; the next
// input transfer is taken once the result is out or leaving.
module dcc_packet_transmitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  dcc_in_if.sink     in_ch,
  dcc_out_if.source  out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_BYTE = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                idle_fill_q;
  logic                out_valid_q, out_valid_d;
  logic                acc_q, acc_d;

  // Line state
  dcc_pkg::ptr_t       read_pos_q, read_pos_d;
  logic                idle_active_q, idle_active_d;
  logic [5:0]          idle_pos_q, idle_pos_d;
  logic [2:0]          half_q, half_d;
  logic                bit_now_q, bit_now_d;
  logic                drv_a_q, drv_a_d;
  logic                drv_b_q, drv_b_d;

  dcc_pkg::ptr_t       write_pos;
  dcc_pkg::wr_t        wr;
  dcc_pkg::frm_stat_t  frm_stat;
  logic                rd_bit;
  logic                in_xfer, byte_start, queued;

  assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign byte_start  = in_xfer && (in_ch.command == dcc_pkg::CMD_BYTE);
  assign queued      = read_pos_q != write_pos;

  dcc_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (byte_start),
    .data_byte_i (in_ch.data_byte),
    .first_i     (in_ch.first_of_packet),
    .last_i      (in_ch.last_of_packet),
    .long_i      (in_ch.long_preamble),
    .read_pos_i  (read_pos_q),
    .write_pos_o (write_pos),
    .wr_o        (wr),
    .stat_o      (frm_stat)
  );

  // Read the head of the ring every cycle; the data is valid in S_TICK.
  dcc_bit_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (read_pos_q),
    .rd_data_o (rd_bit)
  );

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    acc_d         = acc_q;
    read_pos_d    = read_pos_q;
    idle_active_d = idle_active_q;
    idle_pos_d    = idle_pos_q;
    half_d        = half_q;
    bit_now_d     = bit_now_q;
    drv_a_d       = drv_a_q;
    drv_b_d       = drv_b_q;

    // Drop the result once the sink takes it.
    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (in_ch.command == dcc_pkg::CMD_BYTE) ? S_BYTE : S_RD;
        end
      end
      S_RD: begin
        state_d = S_TICK;
      end
      S_TICK: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        acc_d       = 1'b1;
        if (!(idle_active_q && idle_pos_q != 6'd0) && !idle_fill_q && !queued) begin
          // Rest: hold both lines high and restart the bit.
          drv_a_d = 1'b1;
          drv_b_d = 1'b1;
          half_d  = 3'd0;
        end else begin
          if (half_q == 3'd0 || bit_now_q || half_q == 3'd2 || half_q == 3'd4) begin
            drv_b_d = drv_a_q;
            drv_a_d = ~drv_a_q;
          end
          // Pick the source and the bit at the start of each bit time.
          if (half_q == 3'd0) begin
            if (!queued && !idle_active_q) begin
              idle_active_d = 1'b1;
              idle_pos_d    = 6'd0;
            end else if (queued && idle_active_q && idle_pos_q == 6'd0) begin
              idle_active_d = 1'b0;
            end
            bit_now_d = idle_active_d ? dcc_pkg::idle_bit(idle_pos_d) : rd_bit;
          end
          half_d = half_q + 3'd1;
          if ((bit_now_d && half_d >= 3'd2) || (!bit_now_d && half_d >= 3'd4)) begin
            if (idle_active_d) begin
              idle_pos_d = (idle_pos_d == 6'(dcc_pkg::IDLE_BITS - 1)) ? 6'd0
                                                                     : idle_pos_d + 6'd1;
            end else begin
              read_pos_d = dcc_pkg::ptr_next(read_pos_q);
            end
            half_d = 3'd0;
          end
        end
      end
      S_BYTE: begin
        if (frm_stat.done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          acc_d       = frm_stat.stored;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idle_fill_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      acc_q         <= 1'b0;
      read_pos_q    <= '0;
      idle_active_q <= 1'b0;
      idle_pos_q    <= '0;
      half_q        <= '0;
      bit_now_q     <= 1'b0;
      drv_a_q       <= 1'b1;
      drv_b_q       <= 1'b1;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      acc_q         <= acc_d;
      read_pos_q    <= read_pos_d;
      idle_active_q <= idle_active_d;
      idle_pos_q    <= idle_pos_d;
      half_q        <= half_d;
      bit_now_q     <= bit_now_d;
      drv_a_q       <= drv_a_d;
      drv_b_q       <= drv_b_d;
      if (cfg_we_i) begin
        idle_fill_q <= cfg_data_i;
      end
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.track_a  = drv_a_q;
  assign out_ch.track_b  = drv_b_q;
  assign out_ch.accepted = acc_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (!out_valid_q || out_ch.ready))
    else $error("input taken while a result is still held");

  a_half_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q <= 3'd3)
    else $error("half-bit count out of range");

  a_idle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_pos_q < 6'(dcc_pkg::IDLE_BITS))
    else $error("idle packet position out of range");

  a_write_in_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> state_q == S_BYTE)
    else $error("ring written outside byte framing");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TICK |=> out_valid_q && acc_q)
    else $error("tick finished without a result");

endmodule

// ===== bench/tb_dcc_packet_transmitter.sv =====
`timescale 1ns / 1ps

module tb_dcc_packet_transmitter;

  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 50;    // run-out after every result is back
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer

  typedef struct {
    bit         command;
    logic [7:0] data_byte;
    bit         first_of_packet;
    bit         last_of_packet;
    bit         long_preamble;
    bit         wait_empty;  // hold this item until every result is back
  } dcc_item_t;

  typedef struct packed {
    logic track_a;
    logic track_b;
    logic accepted;
  } track_levels_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  dcc_in_if  in_ch ();
  dcc_out_if out_ch ();

  dcc_packet_transmitter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Track encoder shadow: bit ring, read side, framer and bridge line levels.
  // Reset is applied once, so the reset values sit in the declarations.
  // ---------------------------------------------------------------------------
  bit          ring_bits [dcc_pkg::BIT_STORE_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  bit          idle_on = 1'b0;
  int unsigned idle_ptr = 0;
  int unsigned half_cnt = 0;
  bit          cur_bit = 1'b0;
  logic [7:0]  xor_acc = 8'h00;
  bit          line_a = 1'b1;
  bit          line_b = 1'b1;
  bit          fill_on = 1'b0;

  track_levels_t expected_levels [$];
  dcc_item_t     pending [$];

  int unsigned n_ticks = 0;
  int unsigned n_bytes = 0;
  int unsigned n_refused = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // Advance the line drive by one half-bit time.
  function automatic void half_bit_tick();
    bit queued;
    queued = (rd_ptr != wr_ptr);
    // Rest: nothing queued, no idle fill, and no idle packet under way
    if (!(idle_on && idle_ptr > 0) && !fill_on && !queued) begin
      line_a   = 1'b1;
      line_b   = 1'b1;
      half_cnt = 0;
      return;
    end
    // A one toggles every tick, a zero on its first and third tick
    if (half_cnt == 0 || cur_bit || half_cnt == 2 || half_cnt == 4) begin
      line_b = line_a;
      line_a = ~line_a;
    end
    // Choose the source only at a bit boundary; an idle packet runs to its end
    if (half_cnt == 0) begin
      if (!queued && !idle_on) begin
        idle_on  = 1'b1;
        idle_ptr = 0;
      end else if (queued && idle_on && idle_ptr == 0) begin
        idle_on = 1'b0;
      end
      cur_bit = idle_on ? dcc_pkg::IDLE_PKT[dcc_pkg::IDLE_BITS - 1 - idle_ptr]
                        : ring_bits[rd_ptr];
    end
    half_cnt++;
    if ((cur_bit && half_cnt >= 2) || (!cur_bit && half_cnt >= 4)) begin
      if (idle_on)
        idle_ptr = (idle_ptr + 1 >= dcc_pkg::IDLE_BITS) ? 0 : idle_ptr + 1;
      else
        rd_ptr = (rd_ptr + 1) % dcc_pkg::BIT_STORE_DEPTH;
      half_cnt = 0;
    end
  endfunction

  // Frame one packet byte into the ring; return 0 when it does not fit whole.
  function automatic bit frame_byte(logic [7:0] v, bit first, bit last, bit longp);
    bit          frame [$];
    logic [7:0]  chk;
    int unsigned used;
    int unsigned room;
    int          i;
    chk = xor_acc;
    if (first) begin
      repeat (longp ? dcc_pkg::PRE_LONG : dcc_pkg::PRE_SHORT) frame.push_back(1'b1);
      chk = 8'h00;
    end
    frame.push_back(1'b0);
    for (i = 7; i >= 0; i--) frame.push_back(v[i]);
    chk ^= v;
    if (last) begin
      frame.push_back(1'b0);
      for (i = 7; i >= 0; i--) frame.push_back(chk[i]);
      frame.push_back(1'b1);
    end
    used = (wr_ptr + dcc_pkg::BIT_STORE_DEPTH - rd_ptr) % dcc_pkg::BIT_STORE_DEPTH;
    room = dcc_pkg::BIT_STORE_DEPTH - 1 - used;
    // No room for the whole frame: drop the byte, keep the check byte as it was
    if (frame.size() > room) return 1'b0;
    foreach (frame[k]) begin
      ring_bits[wr_ptr] = frame[k];
      wr_ptr = (wr_ptr + 1) % dcc_pkg::BIT_STORE_DEPTH;
    end
    xor_acc = chk;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic void push_item(bit cmd, logic [7:0] v, bit first, bit last,
                                    bit longp, bit wait_empty);
    dcc_item_t it;
    it.command         = cmd;
    it.data_byte       = v;
    it.first_of_packet = first;
    it.last_of_packet  = last;
    it.long_preamble   = longp;
    it.wait_empty      = wait_empty;
    pending.push_back(it);
  endfunction

  // Ticks carry random junk in the fields the block ignores for them.
  function automatic void push_ticks(int unsigned n);
    repeat (n) push_item(dcc_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                         bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
                         bit'($urandom_range(0, 1)), 1'b0);
  endfunction

  function automatic void plan_directed();
    // Rest with an empty ring
    push_ticks(2);
    // Extreme bytes in a short-preamble packet
    push_item(dcc_pkg::CMD_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(dcc_pkg::CMD_BYTE, 8'hff, 1'b0, 1'b1, 1'b0, 1'b0);
    // One-byte packet with the long preamble
    push_item(dcc_pkg::CMD_BYTE, 8'ha5, 1'b1, 1'b1, 1'b1, 1'b0);
    // Last byte without a first: check continues from the previous packet
    push_item(dcc_pkg::CMD_BYTE, 8'h3c, 1'b0, 1'b1, 1'b0, 1'b0);
    // Middle byte, neither first nor last
    push_item(dcc_pkg::CMD_BYTE, 8'h5a, 1'b0, 1'b0, 1'b1, 1'b0);
    push_ticks(4);
    // Longest frames back to back until the ring refuses one; the first waits
    // until every earlier result is back
    for (int k = 0; k < 6; k++)
      push_item(dcc_pkg::CMD_BYTE, 8'(8'h81 + 8'(k * 37)), 1'b1, 1'b1, 1'b1, k == 0);
    push_ticks(3);
  endfunction

  // Mostly well-formed packets with random content separated by tick runs;
  // some noise bytes with random flags. Refusals break packets naturally.
  function automatic void plan_traffic(int unsigned target);
    int unsigned made;
    int unsigned seg;
    int unsigned n;
    bit          longp;
    made = 0;
    seg  = 0;
    while (made < target) begin
      seg++;
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n)
          push_item(dcc_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
                    bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
                    bit'($urandom_range(0, 1)), 1'b0);
      end else begin
        n     = $urandom_range(1, 3);
        longp = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++)
          push_item(dcc_pkg::CMD_BYTE, 8'($urandom_range(0, 255)), k == 0, k == n - 1,
                    longp, (seg % 4 == 2) && k == 0);
      end
      made += n;
      // Occasional long runs let the ring empty so rest and idle fill show up
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 400) : $urandom_range(3, 180);
      push_ticks(n);
      made += n;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one item per transfer, random gap after each, and calm
  // stretches with no gap at all.
  // ---------------------------------------------------------------------------
  int        gap_left;
  bit        in_calm = 1'b0;
  dcc_item_t cur_item;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending.size() != 0 &&
                   !(pending[0].wait_empty &&
                     (expected_levels.size() != 0 || (in_ch.valid && in_ch.ready)))) begin
        cur_item = pending.pop_front();
        in_ch.command         <= cur_item.command;
        in_ch.data_byte       <= cur_item.data_byte;
        in_ch.first_of_packet <= cur_item.first_of_packet;
        in_ch.last_of_packet  <= cur_item.last_of_packet;
        in_ch.long_preamble   <= cur_item.long_preamble;
        in_ch.valid           <= 1'b1;
        gap_left              <= in_calm ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 29) == 0) in_calm <= ~in_calm;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall after each transfer, calm stretches, and a
  // long hold-off whenever the stimulus bumps hold_token.
  // ---------------------------------------------------------------------------
  int hold_token = 0;
  int hold_seen;
  int hold_left;
  int stall_left;
  int out_wait;
  bit out_calm = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
      stall_left   <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      out_wait      = out_calm ? 0 : $urandom_range(0, 18);
      stall_left   <= out_wait;
      out_ch.ready <= (out_wait == 0);
      if ($urandom_range(0, 29) == 0) out_calm <= ~out_calm;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction on every input transfer, checking on every result transfer
  // ---------------------------------------------------------------------------
  bit acc_bit;

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (in_ch.command == dcc_pkg::CMD_TICK) begin
        half_bit_tick();
        acc_bit = 1'b1;
        n_ticks++;
      end else begin
        acc_bit = frame_byte(in_ch.data_byte, in_ch.first_of_packet, in_ch.last_of_packet,
                             in_ch.long_preamble);
        n_bytes++;
        if (!acc_bit) n_refused++;
      end
      expected_levels.push_back('{line_a, line_b, acc_bit});
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 30)
      $display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, results_seen, what,
               got, want);
  endtask

  track_levels_t want_lv;

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("transfer with nothing pending,", 1, 0);
      end else begin
        want_lv = expected_levels.pop_front();
        if (out_ch.track_a !== want_lv.track_a)
          report_mismatch("track_a", out_ch.track_a, want_lv.track_a);
        if (out_ch.track_b !== want_lv.track_b)
          report_mismatch("track_b", out_ch.track_b, want_lv.track_b);
        if (out_ch.accepted !== want_lv.accepted)
          report_mismatch("accepted", out_ch.accepted, want_lv.accepted);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, expected_levels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Wait until the queue is empty and every result is back, then let the
  // block run out its latency. Sample on the falling edge so the checks see
  // settled values.
  task automatic settle();
    @(negedge clk_i);
    while (pending.size() != 0 || in_ch.valid || expected_levels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_idle_fill(bit v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    fill_on     = v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    // Drive every input to a known level before reset releases
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_data_i            = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.command         = dcc_pkg::CMD_TICK;
    in_ch.data_byte       = 8'h00;
    in_ch.first_of_packet = 1'b0;
    in_ch.last_of_packet  = 1'b0;
    in_ch.long_preamble   = 1'b0;
    out_ch.ready          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Lines rest high: directed cases, then random traffic
    write_idle_fill(1'b0);
    @(negedge clk_i);
    plan_directed();
    plan_traffic(200);
    settle();

    // Idle fill on; hold off the receiver while the sender keeps offering
    write_idle_fill(1'b1);
    @(negedge clk_i);
    plan_traffic(230);
    hold_token++;
    settle();

    write_idle_fill(1'b0);
    @(negedge clk_i);
    plan_traffic(200);
    settle();

    write_idle_fill(1'b1);
    @(negedge clk_i);
    plan_traffic(200);
    settle();

    $display("Sent %0d half-bit ticks and %0d packet bytes (%0d refused on a full ring)",
             n_ticks, n_bytes, n_refused);
    $display("with idle fill off and on; %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
